/* sv/fip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fip_pkg
// widths, codes and sequencer states shared by the frame integrate / persist
// block
// ----------------------------------------------------------------------------
package fip_pkg;

	// item fields
	localparam int IDX_W   = 16;
	localparam int VAL_W   = 32;
	localparam int INT_W   = 16;
	localparam int ACQ_W   = 32;
	localparam int EVT_W   = 64;
	localparam int CODE_W  = 2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int GLOW_W     = 15;

	// decay factor in units of UNIT_SCALE
	localparam int UNIT_SHIFT = 16;
	localparam int UNIT_SCALE = 1 << UNIT_SHIFT;
	localparam int DECAY_W    = UNIT_SHIFT + 1;

	localparam int PIXELS_DEFAULT = 256 * 256;
	localparam logic [GLOW_W-1:0] GLOW_RESET = GLOW_W'(4000);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GLOW_EN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GLOW_MS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIG  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_TRIG  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_TRIG = 3'd5;

	// trigger codes
	localparam logic [CODE_W-1:0] TRIG_NONE = 2'd0;
	localparam logic [CODE_W-1:0] TRIG_MAX  = 2'd1;
	localparam logic [CODE_W-1:0] TRIG_SUM  = 2'd2;
	localparam logic [CODE_W-1:0] TRIG_TIME = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD1,
		ST_MOD2,
		ST_FRAME,
		ST_DIV,
		ST_READ,
		ST_CALC,
		ST_MUL,
		ST_WB
	} state_t;

endpackage
`default_nettype wire

/* sv/frame_integrate_or_persist.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_integrate_or_persist
// frame accumulator with decaying persistence over a dual-port image memory
// ----------------------------------------------------------------------------
//
//  channel  handshake               payload
//  -------  ----------------------  -------------------------------------------
//  in       in_valid / in_stall     pixel_index pixel_count frame_int_ms
//                                   frame_acq_ms frame_events
//  out      out_valid / out_stall   out_index out_value frame_end trigger_code
//                                   total_int_ms
//  cfg      cfg_valid / cfg_ready   cfg_index cfg_data
//
//  sequence: accept, address fold in two steps, read, update (one step when
//    integrating, two persisting), write back; a frame start adds a frame step,
//    then the bit-serial decay divider when persisting with a live decay factor
//  reset: the image memory is swept to zero, in_stall high;
//    a write to integrate_enable starts the same sweep; cfg_ready stays high
//  stalls: only the write back waits on a full output register
//
module frame_integrate_or_persist #(
	parameter int PIXELS = fip_pkg::PIXELS_DEFAULT
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// pixel request
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [fip_pkg::IDX_W-1:0]          pixel_index,
	input  wire  [fip_pkg::VAL_W-1:0]          pixel_count,
	input  wire  [fip_pkg::INT_W-1:0]          frame_int_ms,
	input  wire  [fip_pkg::ACQ_W-1:0]          frame_acq_ms,
	input  wire  [fip_pkg::EVT_W-1:0]          frame_events,
	// result request
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [fip_pkg::IDX_W-1:0]          out_index,
	output logic [fip_pkg::VAL_W-1:0]          out_value,
	output logic                               frame_end,
	output logic [fip_pkg::CODE_W-1:0]         trigger_code,
	output logic [fip_pkg::VAL_W-1:0]          total_int_ms,
	// configuration writes
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [fip_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [fip_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IW  = fip_pkg::IDX_W;
	localparam int VW  = fip_pkg::VAL_W;
	localparam int AW  = $clog2(PIXELS);
	localparam int PW  = $clog2(PIXELS + 1);
	localparam int MW  = (PW > IW + 1) ? PW : IW + 1;
	// floor(2^32 / PIXELS): quotient estimate is low by at most one
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / PIXELS);
	localparam int GW  = fip_pkg::GLOW_W;
	localparam int DW  = fip_pkg::DECAY_W;
	localparam int US  = fip_pkg::UNIT_SHIFT;
	localparam int NW  = GW + US;
	localparam int CW  = $clog2(NW);
	localparam int PRW = VW + DW;

	// ------------------------------------------------------------------
	// configuration registers and frame state
	// ------------------------------------------------------------------
	logic                           integ_q;
	logic                           glow_en_q;
	logic [GW-1:0]                  glow_ms_q;
	logic [VW-1:0]                  max_trig_q;
	logic [fip_pkg::EVT_W-1:0]      sum_trig_q;
	logic [fip_pkg::ACQ_W-1:0]      time_trig_q;

	logic [DW-1:0]                  decay_q;
	logic [VW-1:0]                  run_max_q;
	logic [VW-1:0]                  st_int_q;
	logic [fip_pkg::ACQ_W-1:0]      st_acq_q;
	logic [fip_pkg::EVT_W-1:0]      st_evt_q;

	fip_pkg::state_t                state_q, state_d;
	logic [AW-1:0]                  clr_q;

	// item registers
	logic [IW-1:0]                  idx_q;
	logic [VW-1:0]                  count_q;
	logic [fip_pkg::INT_W-1:0]      int_q;
	logic [fip_pkg::ACQ_W-1:0]      acq_q;
	logic [fip_pkg::EVT_W-1:0]      evt_q;

	// address fold pipeline
	logic [IW+31:0]                 prod1_s1;
	logic [IW+PW-1:0]               prod2_s2;
	logic [AW-1:0]                  addr_q;

	// divider
	logic [NW-1:0]                  num_q;
	logic [GW-1:0]                  rem_q;
	logic [DW-1:0]                  quo_q;
	logic [CW-1:0]                  div_cnt_q;

	// update path
	logic [VW-1:0]                  rd_q;
	logic [PRW-1:0]                 mul_q;
	logic [VW-1:0]                  val_q;

	// output register
	logic                           out_valid_q;
	logic [IW-1:0]                  out_index_q;
	logic [VW-1:0]                  out_value_q;
	logic                           frame_end_q;
	logic [fip_pkg::CODE_W-1:0]     trigger_code_q;
	logic [VW-1:0]                  total_int_q;

	// image memory
	logic [VW-1:0]                  mem [PIXELS];

	// ------------------------------------------------------------------
	// combinational helpers
	// ------------------------------------------------------------------
	logic                           in_acc;
	logic                           cfg_wr;
	logic                           cfg_clear;
	logic                           out_free;
	logic                           mem_we;
	logic                           mem_re;
	logic                           wb_go;
	logic [AW-1:0]                  wr_addr;
	logic [VW-1:0]                  wr_data;

	logic [MW-1:0]                  rem_raw;
	logic [MW-1:0]                  rem_fix;
	logic [IW-1:0]                  q_est;

	logic [GW:0]                    div_sh;
	logic                           div_ge;
	logic [GW-1:0]                  div_rem_n;
	logic [DW-1:0]                  div_quo_n;

	logic [VW:0]                    sat_sum;
	logic [VW:0]                    int_sum;
	logic [VW-1:0]                  kept;
	logic [VW-1:0]                  new_max;
	logic                           last;
	logic [fip_pkg::CODE_W-1:0]     code;
	logic                           decay_on;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_clear = cfg_wr && (cfg_index == fip_pkg::REG_INTEGRATE);
	assign out_free  = !out_valid_q || !out_stall;

	// pixel_index modulo PIXELS: reciprocal estimate, then one correction
	assign q_est   = prod1_s1[IW+31:32];
	assign rem_raw = MW'(idx_q) - MW'(prod2_s2);
	assign rem_fix = (rem_raw >= MW'(PIXELS)) ? rem_raw - MW'(PIXELS) : rem_raw;

	// one restoring divide step
	assign div_sh    = {rem_q, num_q[NW-1]};
	assign div_ge    = div_sh >= {1'b0, glow_ms_q};
	assign div_rem_n = div_ge ? GW'(div_sh - {1'b0, glow_ms_q}) : div_sh[GW-1:0];
	assign div_quo_n = {quo_q[DW-2:0], div_ge};

	assign decay_on = glow_en_q && (glow_ms_q != '0)
		&& (int_q < fip_pkg::INT_W'(glow_ms_q));

	assign sat_sum = {1'b0, rd_q} + {1'b0, count_q};
	assign int_sum = {1'b0, st_int_q} + (VW+1)'(int_q);
	assign kept    = mul_q[US+VW-1:US];

	// trigger checks on the last pixel, later checks win
	assign new_max = (val_q > run_max_q) ? val_q : run_max_q;
	assign last    = (PW'(addr_q) == PW'(PIXELS - 1));
	always_comb begin
		code = fip_pkg::TRIG_NONE;
		if (last) begin
			if (max_trig_q != '0 && max_trig_q < new_max)
				code = fip_pkg::TRIG_MAX;
			if (sum_trig_q != '0 && sum_trig_q < st_evt_q)
				code = fip_pkg::TRIG_SUM;
			if (time_trig_q != '0 && time_trig_q < st_acq_q)
				code = fip_pkg::TRIG_TIME;
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fip_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		mem_re   = 1'b0;
		wb_go    = 1'b0;
		unique case (state_q)
			fip_pkg::ST_CLEAR: begin
				if (clr_q == AW'(PIXELS - 1))
					state_d = fip_pkg::ST_IDLE;
			end
			fip_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					state_d = fip_pkg::ST_MOD1;
			end
			fip_pkg::ST_MOD1: begin
				state_d = fip_pkg::ST_MOD2;
			end
			fip_pkg::ST_MOD2: begin
				state_d = (rem_fix == '0) ? fip_pkg::ST_FRAME : fip_pkg::ST_READ;
			end
			fip_pkg::ST_FRAME: begin
				state_d = (!integ_q && decay_on) ? fip_pkg::ST_DIV : fip_pkg::ST_READ;
			end
			fip_pkg::ST_DIV: begin
				if (div_cnt_q == '0)
					state_d = fip_pkg::ST_READ;
			end
			fip_pkg::ST_READ: begin
				mem_re  = 1'b1;
				state_d = fip_pkg::ST_CALC;
			end
			fip_pkg::ST_CALC: begin
				state_d = integ_q ? fip_pkg::ST_WB : fip_pkg::ST_MUL;
			end
			fip_pkg::ST_MUL: begin
				state_d = fip_pkg::ST_WB;
			end
			fip_pkg::ST_WB: begin
				if (out_free) begin
					wb_go   = 1'b1;
					state_d = fip_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fip_pkg::ST_CLEAR;
			end
		endcase
		// any write to integrate_enable restarts the sweep
		if (cfg_clear)
			state_d = fip_pkg::ST_CLEAR;
	end

	assign mem_we  = (state_q == fip_pkg::ST_CLEAR) || wb_go;
	assign wr_addr = (state_q == fip_pkg::ST_CLEAR) ? clr_q : addr_q;
	assign wr_data = (state_q == fip_pkg::ST_CLEAR) ? '0 : val_q;

	// ------------------------------------------------------------------
	// image memory, one write and one registered read a cycle
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_data;
		if (mem_re)
			rd_q <= mem[addr_q];
	end

	// ------------------------------------------------------------------
	// control state: configuration, frame values, sweep, output valid
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= 1'b0;
			glow_en_q   <= 1'b1;
			glow_ms_q   <= fip_pkg::GLOW_RESET;
			max_trig_q  <= '0;
			sum_trig_q  <= '0;
			time_trig_q <= '0;
			decay_q     <= '0;
			run_max_q   <= '0;
			st_int_q    <= '0;
			st_acq_q    <= '0;
			st_evt_q    <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == fip_pkg::ST_CLEAR)
				clr_q <= clr_q + AW'(1);

			// frame start
			if (state_q == fip_pkg::ST_FRAME) begin
				run_max_q <= '0;
				if (integ_q) begin
					st_int_q <= int_sum[VW] ? '1 : int_sum[VW-1:0];
				end else begin
					st_int_q <= VW'(int_q);
					st_acq_q <= acq_q;
					st_evt_q <= evt_q;
					if (!decay_on)
						decay_q <= '0;
				end
			end
			if (state_q == fip_pkg::ST_DIV && div_cnt_q == '0)
				decay_q <= div_quo_n;

			if (wb_go)
				run_max_q <= new_max;

			// result register
			if (wb_go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (cfg_wr) begin
				unique case (cfg_index)
					fip_pkg::REG_INTEGRATE: begin
						integ_q   <= cfg_data[0];
						run_max_q <= '0;
						st_int_q  <= '0;
						st_acq_q  <= '0;
						st_evt_q  <= '0;
						clr_q     <= '0;
					end
					fip_pkg::REG_GLOW_EN:   glow_en_q   <= cfg_data[0];
					fip_pkg::REG_GLOW_MS:   glow_ms_q   <= cfg_data[GW-1:0];
					fip_pkg::REG_MAX_TRIG:  max_trig_q  <= cfg_data[VW-1:0];
					fip_pkg::REG_SUM_TRIG:  sum_trig_q  <= cfg_data;
					fip_pkg::REG_TIME_TRIG: time_trig_q <= cfg_data[fip_pkg::ACQ_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q    <= pixel_index;
			count_q  <= pixel_count;
			int_q    <= frame_int_ms;
			acq_q    <= frame_acq_ms;
			evt_q    <= frame_events;
			prod1_s1 <= pixel_index * RECIP;
		end

		if (state_q == fip_pkg::ST_MOD1)
			prod2_s2 <= q_est * PW'(PIXELS);
		if (state_q == fip_pkg::ST_MOD2)
			addr_q <= rem_fix[AW-1:0];

		// decay numerator (glow - int) * UNIT_SCALE
		if (state_q == fip_pkg::ST_FRAME) begin
			num_q     <= {GW'(fip_pkg::INT_W'(glow_ms_q) - int_q), US'(0)};
			rem_q     <= '0;
			quo_q     <= '0;
			div_cnt_q <= CW'(NW - 1);
		end
		if (state_q == fip_pkg::ST_DIV) begin
			num_q     <= {num_q[NW-2:0], 1'b0};
			rem_q     <= div_rem_n;
			quo_q     <= div_quo_n;
			div_cnt_q <= div_cnt_q - CW'(1);
		end

		if (state_q == fip_pkg::ST_CALC) begin
			if (integ_q)
				val_q <= sat_sum[VW] ? '1 : sat_sum[VW-1:0];
			else
				mul_q <= rd_q * decay_q;
		end
		if (state_q == fip_pkg::ST_MUL)
			val_q <= (count_q > kept) ? count_q : kept;

		if (wb_go) begin
			out_index_q    <= idx_q;
			out_value_q    <= val_q;
			frame_end_q    <= last;
			trigger_code_q <= code;
			total_int_q    <= st_int_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_index    = out_index_q;
	assign out_value    = out_value_q;
	assign frame_end    = frame_end_q;
	assign trigger_code = trigger_code_q;
	assign total_int_ms = total_int_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_code_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> trigger_code == fip_pkg::TRIG_NONE)
		else $error("trigger code without frame end");

	a_decay_range: assert property (@(posedge clk) disable iff (!arst_n)
		decay_q <= DW'(fip_pkg::UNIT_SCALE))
		else $error("decay factor above unit");

	a_addr_folded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fip_pkg::ST_READ |-> MW'(addr_q) < MW'(PIXELS))
		else $error("pixel address not folded into store");

	a_clear_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_clear |=> state_q == fip_pkg::ST_CLEAR && clr_q == '0)
		else $error("integrate write did not restart sweep");

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the frame integrate / persist block: pixel requests
// go in, each result request is compared field by field against an in-bench
// model of the image store, decay factor, frame totals and trigger logic,
// over directed frames, several register settings and random sparse frames
// under random gaps, output stalls and one long output hold
// ----------------------------------------------------------------------------
module tb;

	// shared widths and codes
	localparam int IDX_W          = fip_pkg::IDX_W;
	localparam int VAL_W          = fip_pkg::VAL_W;
	localparam int INT_W          = fip_pkg::INT_W;
	localparam int ACQ_W          = fip_pkg::ACQ_W;
	localparam int EVT_W          = fip_pkg::EVT_W;
	localparam int CODE_W         = fip_pkg::CODE_W;
	localparam int CFG_IDX_W      = fip_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W     = fip_pkg::CFG_DATA_W;
	localparam int GLOW_W         = fip_pkg::GLOW_W;
	localparam int UNIT_SHIFT     = fip_pkg::UNIT_SHIFT;
	localparam int DECAY_W        = fip_pkg::DECAY_W;
	localparam int PIXELS_DEFAULT = fip_pkg::PIXELS_DEFAULT;
	localparam logic [GLOW_W-1:0] GLOW_RESET = fip_pkg::GLOW_RESET;

	localparam logic [CFG_IDX_W-1:0] REG_INTEGRATE = fip_pkg::REG_INTEGRATE;
	localparam logic [CFG_IDX_W-1:0] REG_GLOW_EN   = fip_pkg::REG_GLOW_EN;
	localparam logic [CFG_IDX_W-1:0] REG_GLOW_MS   = fip_pkg::REG_GLOW_MS;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIG  = fip_pkg::REG_MAX_TRIG;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_TRIG  = fip_pkg::REG_SUM_TRIG;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_TRIG = fip_pkg::REG_TIME_TRIG;

	localparam logic [CODE_W-1:0] TRIG_NONE = fip_pkg::TRIG_NONE;
	localparam logic [CODE_W-1:0] TRIG_MAX  = fip_pkg::TRIG_MAX;
	localparam logic [CODE_W-1:0] TRIG_SUM  = fip_pkg::TRIG_SUM;
	localparam logic [CODE_W-1:0] TRIG_TIME = fip_pkg::TRIG_TIME;

	localparam int LONG_HOLD      = 400;     // output hold that fills the block
	localparam int WATCHDOG_LIMIT = 200_000; // three clearing sweeps of the store
	localparam int DRAIN_CYCLES   = 64;      // a divide plus one pixel, with margin
	localparam int RANDOM_PHASES  = 5;
	localparam int PHASE_PIXELS   = 185;
	localparam logic [IDX_W-1:0] LAST_INDEX = '1;

	typedef struct {
		logic [IDX_W-1:0]  index;
		logic [VAL_W-1:0]  value;
		logic              last;
		logic [CODE_W-1:0] code;
		logic [VAL_W-1:0]  int_total;
	} pixel_result_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SQUARE} stall_mode_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// pixel request side
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [IDX_W-1:0]  pixel_index  = '0;
	logic [VAL_W-1:0]  pixel_count  = '0;
	logic [INT_W-1:0]  frame_int_ms = '0;
	logic [ACQ_W-1:0]  frame_acq_ms = '0;
	logic [EVT_W-1:0]  frame_events = '0;

	// result request side
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [IDX_W-1:0]  out_index;
	logic [VAL_W-1:0]  out_value;
	logic              frame_end;
	logic [CODE_W-1:0] trigger_code;
	logic [VAL_W-1:0]  total_int_ms;

	// register writes
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// model of the block: image store, per-frame state and registers
	logic [VAL_W-1:0]   img_mem [PIXELS_DEFAULT];
	logic [DECAY_W-1:0] decay_q;
	logic [VAL_W-1:0]   frame_peak;
	logic [VAL_W-1:0]   acc_int_ms;
	logic [ACQ_W-1:0]   acq_q;
	logic [EVT_W-1:0]   events_q;
	logic               cfg_integrate;
	logic               cfg_glow_en;
	logic [GLOW_W-1:0]  cfg_glow_ms;
	logic [VAL_W-1:0]   cfg_max_trig;
	logic [EVT_W-1:0]   cfg_sum_trig;
	logic [ACQ_W-1:0]   cfg_time_trig;

	// results still owed by the block, oldest first
	pixel_result_t results_due [$];

	// bookkeeping
	int errors        = 0;
	int pixels_sent   = 0;
	int results_seen  = 0;
	int frames_closed = 0;
	int code_seen [4] = '{0, 0, 0, 0};
	int quiet_cycles  = 0;

	// sender pacing
	bit offering   = 1'b0;
	bit cfg_active = 1'b0;
	bit gaps_off   = 1'b0;
	int burst_left = 0;

	// receiver pacing, the hold request is a counter bumped by the test
	int          hold_seq    = 0;
	int          hold_seen   = 0;
	int          hold_left   = 0;
	int          stall_left  = 0;
	stall_mode_t stall_mode  = STALL_NONE;

	frame_integrate_or_persist u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_index  (pixel_index),
		.pixel_count  (pixel_count),
		.frame_int_ms (frame_int_ms),
		.frame_acq_ms (frame_acq_ms),
		.frame_events (frame_events),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_index    (out_index),
		.out_value    (out_value),
		.frame_end    (frame_end),
		.trigger_code (trigger_code),
		.total_int_ms (total_int_ms),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// model
	// ------------------------------------------------------------------------

	// what a write to integrate_enable wipes; the decay factor survives it
	function automatic void clear_image();
		foreach (img_mem[i])
			img_mem[i] = '0;
		frame_peak = '0;
		acc_int_ms = '0;
		acq_q      = '0;
		events_q   = '0;
	endfunction

	function automatic void reset_model();
		clear_image();
		decay_q       = '0;
		cfg_integrate = 1'b0;
		cfg_glow_en   = 1'b1;
		cfg_glow_ms   = GLOW_RESET;
		cfg_max_trig  = '0;
		cfg_sum_trig  = '0;
		cfg_time_trig = '0;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
		REG_INTEGRATE: begin
			cfg_integrate = data[0];
			clear_image();
		end
		REG_GLOW_EN:   cfg_glow_en   = data[0];
		REG_GLOW_MS:   cfg_glow_ms   = data[GLOW_W-1:0];
		REG_MAX_TRIG:  cfg_max_trig  = data[VAL_W-1:0];
		REG_SUM_TRIG:  cfg_sum_trig  = data;
		REG_TIME_TRIG: cfg_time_trig = data[ACQ_W-1:0];
		default: ;
		endcase
	endfunction

	// one pixel through the store; the store holds every 16-bit index, so the
	// address is the index itself
	function automatic pixel_result_t advance_image(input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] cnt, input logic [INT_W-1:0] int_ms,
			input logic [ACQ_W-1:0] acq, input logic [EVT_W-1:0] evt);
		pixel_result_t r;
		logic [VAL_W:0]   wide_sum;
		logic [63:0]      scaled;
		logic [VAL_W-1:0] kept;
		logic [VAL_W-1:0] v;
		if (idx == '0) begin
			// frame start: frame totals and a fresh decay factor
			frame_peak = '0;
			if (cfg_integrate) begin
				wide_sum   = {1'b0, acc_int_ms} + int_ms;
				acc_int_ms = wide_sum[VAL_W] ? '1 : wide_sum[VAL_W-1:0];
			end else begin
				acc_int_ms = VAL_W'(int_ms);
				acq_q      = acq;
				events_q   = evt;
				// glow off, zero glow time or integration at or past the glow time: no decay
				if (cfg_glow_en && cfg_glow_ms != '0 && int_ms < cfg_glow_ms)
					decay_q = DECAY_W'(((64'(cfg_glow_ms) - 64'(int_ms)) << UNIT_SHIFT)
						/ 64'(cfg_glow_ms));
				else
					decay_q = '0;
			end
		end
		if (cfg_integrate) begin
			wide_sum = {1'b0, img_mem[idx]} + cnt;
			v = wide_sum[VAL_W] ? '1 : wide_sum[VAL_W-1:0];
		end else begin
			scaled = (64'(img_mem[idx]) * 64'(decay_q)) >> UNIT_SHIFT;
			kept   = scaled[VAL_W-1:0];
			v      = (cnt > kept) ? cnt : kept;
		end
		img_mem[idx] = v;
		if (v > frame_peak)
			frame_peak = v;
		r.index = idx;
		r.value = v;
		r.last  = (idx == LAST_INDEX);
		r.code  = TRIG_NONE;
		if (r.last) begin
			// later checks override earlier ones
			if (cfg_max_trig != '0 && cfg_max_trig < frame_peak)
				r.code = TRIG_MAX;
			if (cfg_sum_trig != '0 && cfg_sum_trig < events_q)
				r.code = TRIG_SUM;
			if (cfg_time_trig != '0 && cfg_time_trig < acq_q)
				r.code = TRIG_TIME;
		end
		r.int_total = acc_int_ms;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// drivers, all called right after a rising edge
	// ------------------------------------------------------------------------

	// offer one pixel request, hold it until taken, then maybe open a gap
	task automatic send_pixel(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] cnt,
			input logic [INT_W-1:0] int_ms, input logic [ACQ_W-1:0] acq,
			input logic [EVT_W-1:0] evt);
		int gap;
		in_valid     <= 1'b1;
		pixel_index  <= idx;
		pixel_count  <= cnt;
		frame_int_ms <= int_ms;
		frame_acq_ms <= acq;
		frame_events <= evt;
		offering = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		results_due.push_back(advance_image(idx, cnt, int_ms, acq, evt));
		pixels_sent++;
		if (!gaps_off) begin
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0) begin
				// mostly short bursts, now and then a long run with no gaps at all
				burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 12);
				gap = $urandom_range(0, 10);
				if (gap != 0) begin
					in_valid <= 1'b0;
					offering = 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	// stop offering and wait until every owed result has been taken
	task automatic wait_drained();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	// register writes keep valid high across a group, end_writes drops it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_active = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_reg(idx, data);
	endtask

	task automatic end_writes();
		if (cfg_active) begin
			cfg_valid <= 1'b0;
			cfg_active = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------------
	// random value helpers
	// ------------------------------------------------------------------------

	function automatic logic [VAL_W-1:0] rand_count();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return '1;
		2: return VAL_W'($urandom_range(0, 255));
		3: return VAL_W'(32'hFFFF_FF00 + $urandom_range(0, 255));
		default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_threshold32();
		case ($urandom_range(0, 3))
		0: return '0;
		1: return '1;
		2: return 32'($urandom_range(1, 2000));
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [EVT_W-1:0] rand_events();
		case ($urandom_range(0, 3))
		0: return '0;
		1: return '1;
		2: return EVT_W'($urandom_range(0, 5000));
		default: return {$urandom, $urandom};
		endcase
	endfunction

	// mostly a small pool so pixels come back frame after frame and decay
	function automatic logic [IDX_W-1:0] rand_mid_index();
		if ($urandom_range(0, 3) == 0)
			return IDX_W'($urandom_range(1, 65534));
		return IDX_W'($urandom_range(1, 12));
	endfunction

	// a sparse frame: start pixel, a handful of inner pixels, usually the end pixel
	task automatic send_random_frame();
		logic [INT_W-1:0] f_int;
		logic [ACQ_W-1:0] f_acq;
		int               inner;
		case ($urandom_range(0, 4))
		0, 1, 2: f_int = INT_W'($urandom_range(0, cfg_glow_ms));
		3:       f_int = INT_W'($urandom);
		default: f_int = INT_W'($urandom_range(0, 20));
		endcase
		f_acq = $urandom_range(0, 1) ? $urandom : ACQ_W'($urandom_range(0, 2000));
		send_pixel('0, rand_count(), f_int, f_acq, rand_events());
		inner = $urandom_range(0, 8);
		repeat (inner)
			send_pixel(rand_mid_index(), rand_count(), INT_W'($urandom), $urandom,
				{$urandom, $urandom});
		// some frames are left open, the next start simply begins another
		if ($urandom_range(0, 9) != 0)
			send_pixel(LAST_INDEX, rand_count(), INT_W'($urandom), $urandom,
				{$urandom, $urandom});
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset settings: persistence with glow on at 4000 ms, no triggers
	task automatic test_persist_basics();
		// pixel ahead of any frame start uses the reset decay of zero
		send_pixel(16'd5, 32'd7, '0, '0, '0);
		// zero integration time gives a full-scale factor, old values kept whole
		send_pixel('0, '0, '0, '0, '0);
		send_pixel(16'd5, '0, '1, '1, '1);
		send_pixel(16'd5, '1, '0, '0, '0);
		send_pixel(LAST_INDEX, 32'd3, '0, '0, '0);
		// a quarter of the glow time used up
		send_pixel('0, '0, 16'd1000, '1, '1);
		send_pixel(16'd5, 32'd1, '0, '0, '0);
		send_pixel(LAST_INDEX, '0, '0, '0, '0);
		// integration past the glow time, then exactly equal to it
		send_pixel('0, '0, '1, '0, '0);
		send_pixel(16'd5, 32'd2, '0, '0, '0);
		send_pixel('0, 32'd9, 16'd4000, '0, '0);
		send_pixel(LAST_INDEX, '0, '0, '0, '0);
		wait_drained();
	endtask

	// each trigger alone and the later checks overriding the earlier ones
	task automatic test_triggers();
		write_reg(REG_MAX_TRIG, 64'd100);
		write_reg(REG_SUM_TRIG, 64'd1000);
		write_reg(REG_TIME_TRIG, 64'd50);
		end_writes();
		send_pixel('0, 32'd200, '0, 32'd10, 64'd10);
		send_pixel(LAST_INDEX, '0, '0, '0, '0);
		send_pixel('0, '0, '0, 32'd10, 64'd2000);
		send_pixel(LAST_INDEX, '0, '0, '0, '0);
		send_pixel('0, '0, '0, 32'd60, 64'd2000);
		send_pixel(LAST_INDEX, '0, '0, '0, '0);
		wait_drained();
	endtask

	// glow off, zero glow time and the widest glow time
	task automatic test_glow_settings();
		write_reg(REG_GLOW_EN, 64'd0);
		end_writes();
		send_pixel('0, 32'd4, '0, '0, '0);
		send_pixel(LAST_INDEX, '0, '0, '0, '0);
		wait_drained();
		write_reg(REG_GLOW_EN, 64'd1);
		write_reg(REG_GLOW_MS, 64'd0);
		end_writes();
		send_pixel('0, '0, '0, '0, '0);
		send_pixel(LAST_INDEX, '0, '0, '0, '0);
		wait_drained();
		write_reg(REG_GLOW_MS, 64'h7FFF);
		end_writes();
		send_pixel('0, 32'd1, 16'd1, '0, '0);
		send_pixel(LAST_INDEX, '0, '0, '0, '0);
		wait_drained();
	endtask

	// integration mode: pixel sums saturate at the top, time sums accumulate
	task automatic test_integrate_saturation();
		write_reg(REG_MAX_TRIG, 64'hFFFF_FFFE);
		// integrate_enable last, its store sweep then overlaps the first request
		write_reg(REG_INTEGRATE, 64'd1);
		end_writes();
		send_pixel('0, '1, '1, '1, '1);
		send_pixel('0, 32'd1, '1, '0, '0);
		send_pixel(LAST_INDEX, 32'd5, '0, '0, '0);
		wait_drained();
	endtask

	// the receiver holds off long enough for the block to stall its input,
	// then the sender pauses until everything is back before carrying on
	task automatic test_long_hold();
		hold_seq <= hold_seq + 1;
		gaps_off = 1'b1;
		send_pixel('0, rand_count(), 16'd100, $urandom, rand_events());
		repeat (30)
			send_pixel(rand_mid_index(), rand_count(), '0, '0, '0);
		send_pixel(LAST_INDEX, rand_count(), '0, '0, '0);
		gaps_off = 1'b0;
		wait_drained();
		repeat (2)
			send_random_frame();
		wait_drained();
	endtask

	// fresh register settings for each phase, extremes spread over the phases
	task automatic random_settings(input int ph);
		write_reg(REG_GLOW_EN, (ph == 1) ? 64'd0 : 64'($urandom_range(0, 4) != 0));
		case (ph % 4)
		0:       write_reg(REG_GLOW_MS, 64'd1);
		1:       write_reg(REG_GLOW_MS, 64'h7FFF);
		2:       write_reg(REG_GLOW_MS, 64'($urandom_range(1, 32000)));
		default: write_reg(REG_GLOW_MS, 64'($urandom_range(2000, 32000)));
		endcase
		write_reg(REG_MAX_TRIG, 64'(rand_threshold32()));
		write_reg(REG_SUM_TRIG, (ph == 0) ? '1 : rand_events());
		write_reg(REG_TIME_TRIG, (ph == 2) ? 64'hFFFF_FFFF : 64'(rand_threshold32()));
		// mode changes clear the store, so only a few phases touch it
		if (ph % 2 == 0)
			write_reg(REG_INTEGRATE, 64'(ph == 2));
		end_writes();
	endtask

	task automatic test_random_phases();
		int target;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			random_settings(ph);
			target = pixels_sent + PHASE_PIXELS;
			while (pixels_sent < target) begin
				if ($urandom_range(0, 6) == 0)
					// stray request anywhere in the raster, frame fields and all
					send_pixel(IDX_W'($urandom), rand_count(), INT_W'($urandom), $urandom,
						{$urandom, $urandom});
				else
					send_random_frame();
			end
			wait_drained();
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		reset_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_persist_basics();
		test_triggers();
		test_glow_settings();
		test_integrate_saturation();
		test_random_phases();
		test_long_hold();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (results_due.size() != 0) begin
			$error("%0d results never arrived", results_due.size());
			errors++;
		end
		$display("run: %0d pixel requests, %0d results checked, %0d frame ends",
			pixels_sent, results_seen, frames_closed);
		$display("trigger codes at frame end: none %0d, max %0d, sum %0d, time %0d",
			code_seen[TRIG_NONE], code_seen[TRIG_MAX], code_seen[TRIG_SUM],
			code_seen[TRIG_TIME]);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// receiver: stall pattern of its own, plus the long hold on request
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (stall_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				stall_left = $urandom_range(20, 150);
			end
			stall_left--;
			case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= stall_left[2];
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// result check against the oldest owed result
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		pixel_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (results_due.size() == 0) begin
				$error("result for index %0d with none owed", out_index);
				errors++;
			end else begin
				want = results_due.pop_front();
				if (out_index !== want.index) begin
					$error("out_index: expected %0d, got %0d", want.index, out_index);
					errors++;
				end
				if (out_value !== want.value) begin
					$error("out_value: expected %0h, got %0h", want.value, out_value);
					errors++;
				end
				if (frame_end !== want.last) begin
					$error("frame_end: expected %0b, got %0b", want.last, frame_end);
					errors++;
				end
				if (trigger_code !== want.code) begin
					$error("trigger_code: expected %0d, got %0d", want.code, trigger_code);
					errors++;
				end
				if (total_int_ms !== want.int_total) begin
					$error("total_int_ms: expected %0d, got %0d", want.int_total,
						total_int_ms);
					errors++;
				end
				if (want.last) begin
					frames_closed++;
					code_seen[want.code]++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long without any request taken on any channel
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request taken for %0d cycles", quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule

/* sim.f */
sv/fip_pkg.sv
sv/frame_integrate_or_persist.sv
verif/tb.sv
